// ===== rtl/bsm_pkg.sv =====
// Shared constants, types and the Booth recoding function for the Booth multiplier.
package bsm_pkg;

  // Width of the operand and product ports.
  localparam int unsigned FIELD_W = 32;

  // Default datapath width of the Booth array.
  localparam int unsigned WIDTH_DEF = 32;

  // Operation that one radix-2 Booth step applies to the accumulator.
  typedef enum logic [1:0] {
    BOOTH_NOP = 2'd0,
    BOOTH_ADD = 2'd1,
    BOOTH_SUB = 2'd2
  } booth_op_t;

  // Recode the current multiplier bit and the bit shifted out before it.
  function automatic booth_op_t booth_decode(input logic cur, input logic prev);
    booth_op_t op;
    unique case ({cur, prev})
      2'b10:   op = BOOTH_SUB;
      2'b01:   op = BOOTH_ADD;
      default: op = BOOTH_NOP;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/bsm_cell.sv =====
// One radix-2 Booth step with its pipeline register.
module bsm_cell
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] acc_i,
  input  logic [WIDTH-1:0] q_i,
  input  logic             prev_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] acc_o,
  output logic [WIDTH-1:0] q_o,
  output logic             prev_o,
  output logic [WIDTH-1:0] m_o
);

  logic             valid_r;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic             prev_r, prev_nxt;
  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] sum;

  always_comb begin
    unique case (booth_decode(q_i[0], prev_i))
      BOOTH_ADD: sum = acc_i + m_i;
      BOOTH_SUB: sum = acc_i - m_i;
      default:   sum = acc_i;
    endcase
    // Arithmetic right shift of the accumulator and multiplier pair.
    acc_nxt  = {sum[WIDTH-1], sum[WIDTH-1:1]};
    q_nxt    = {sum[0], q_i[WIDTH-1:1]};
    prev_nxt = q_i[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    prev_r <= prev_nxt;
    m_r    <= m_i;
  end

  assign valid_o = valid_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;
  assign prev_o  = prev_r;
  assign m_o     = m_r;

endmodule

// ===== rtl/booth_signed_multiplier.sv =====
// Top level of the pipelined radix-2 Booth signed multiplier.
//
// This block multiplies two signed 32-bit operands and returns the low word
// of their two's complement product; overflow wraps. A beat is accepted on
// every rising edge where start is high and busy is low. Busy is never
// raised, so a new operand pair can be issued in every cycle and the block
// sustains one beat per clock. Each beat travels through a chain of WIDTH
// identical cells, one Booth step per cell, followed by an output register.
// The first cell captures the beat at the accepting edge. The beat then
// moves through the remaining cells and the output register, whose outputs
// drive out_valid and out_product_low. The result is shown for exactly one
// cycle with out_valid high; the receiver cannot stall the block and must
// take it in that cycle. Results leave in issue order.
// WIDTH sets the internal datapath width: operands are sign-extended or
// truncated to WIDTH bits, and the WIDTH-bit product is sign-extended or
// truncated back to 32 bits.
module booth_signed_multiplier
  import bsm_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FIELD_W-1:0] in_multiplicand,
  input  logic signed [FIELD_W-1:0] in_multiplier,
  output logic                      out_valid,
  output logic signed [FIELD_W-1:0] out_product_low
);

  // Signals between the cells; index 0 feeds the first cell.
  logic             stg_valid [WIDTH+1];
  logic [WIDTH-1:0] stg_acc   [WIDTH+1];
  logic [WIDTH-1:0] stg_q     [WIDTH+1];
  logic             stg_prev  [WIDTH+1];
  logic [WIDTH-1:0] stg_m     [WIDTH+1];

  logic signed [WIDTH-1:0] mcand_w;
  logic signed [WIDTH-1:0] mplier_w;
  logic signed [WIDTH-1:0] prod_w;

  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] out_product_low_r, out_product_low_nxt;

  // The pipeline never stalls, so the block is always ready for a beat.
  assign busy = 1'b0;

  // Size casts of signed values sign-extend or truncate as needed.
  assign mcand_w  = WIDTH'(in_multiplicand);
  assign mplier_w = WIDTH'(in_multiplier);

  // The accumulator starts at zero and the bit below the multiplier is zero.
  assign stg_valid[0] = start & ~busy;
  assign stg_acc[0]   = '0;
  assign stg_q[0]     = mplier_w;
  assign stg_prev[0]  = 1'b0;
  assign stg_m[0]     = mcand_w;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bsm_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(stg_valid[i]),
      .acc_i  (stg_acc[i]),
      .q_i    (stg_q[i]),
      .prev_i (stg_prev[i]),
      .m_i    (stg_m[i]),
      .valid_o(stg_valid[i+1]),
      .acc_o  (stg_acc[i+1]),
      .q_o    (stg_q[i+1]),
      .prev_o (stg_prev[i+1]),
      .m_o    (stg_m[i+1])
    );
  end

  // After WIDTH steps the multiplier register holds the low product word;
  // the high word left in the accumulator is dropped.
  assign prod_w              = stg_q[WIDTH];
  assign out_product_low_nxt = FIELD_W'(prod_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid[WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    out_product_low_r <= out_product_low_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_product_low = out_product_low_r;

endmodule
